>>> hdl/khi_pkg.sv
// Shared types and constants for the k-mer hash index insert block.
// No dependencies; imported by every module of the block.
package khi_pkg;

  localparam int INDEX_BITS   = 20;
  localparam int BUCKET_SLOTS = 8;
  localparam int TABLE_DEPTH  = (2 ** INDEX_BITS) + BUCKET_SLOTS;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);

  localparam int GROUP_W = 64;
  localparam int HALF_W  = 32;
  localparam int POS_W   = 27;
  localparam int CHECK_W = 5;
  localparam int ENTRY_W = 32;
  localparam int SLOT_W  = 3;
  localparam int CNT_W   = 28;

  localparam logic [GROUP_W-1:0] HASH_MULT = 64'd12345679123456789;
  localparam logic [HALF_W-1:0]  MULT_LO   = HASH_MULT[HALF_W-1:0];
  localparam logic [HALF_W-1:0]  MULT_HI   = HASH_MULT[GROUP_W-1:HALF_W];
  localparam logic [CNT_W-1:0]   COUNT_MAX = 28'h0ffffff_f;

  // Request queue between hash front and table back.
  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [INDEX_BITS-1:0] home;
    logic [ENTRY_W-1:0]    entry;
  } job_t;

endpackage

>>> hdl/khi_front.sv
// Front part: accepts requests and computes the multiplicative hash.
// Depends on khi_pkg; feeds khi_fifo.
module khi_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [63:0]              group_value_i,
  input  logic [26:0]              word_position_i,
  input  logic                     clearing_i,
  input  logic                     full_i,
  output logic                     push_o,
  output khi_pkg::job_t            job_o
);
  import khi_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

  fstate_t             state_r;
  logic [1:0]          step_r;
  logic [HALF_W-1:0]   gl_r, gh_r;
  logic [POS_W-1:0]    pos_r;
  logic [GROUP_W-1:0]  prod_r;
  logic [HALF_W-1:0]   acc_r;
  logic [HALF_W-1:0]   mul_a, mul_b;
  logic [GROUP_W-1:0]  prod_nxt;
  logic [HALF_W-1:0]   hash;
  logic                accept;

  assign busy_o = (state_r != F_IDLE) || clearing_i;
  assign accept = start_i && !busy_o;

  // One shared 32x32 multiplier; pick the partial product for this step.
  always_comb begin
    unique case (step_r)
      2'd0:    begin mul_a = gl_r; mul_b = MULT_LO; end
      2'd1:    begin mul_a = gh_r; mul_b = MULT_LO; end
      default: begin mul_a = gl_r; mul_b = MULT_HI; end
    endcase
    prod_nxt = GROUP_W'(mul_a) * GROUP_W'(mul_b);
  end

  assign hash   = acc_r + prod_r[HALF_W-1:0];
  assign push_o = (state_r == F_PUSH) && !full_i;
  assign job_o  = '{home:  hash[INDEX_BITS-1:0],
                    entry: {hash[HALF_W-1 -: CHECK_W], pos_r}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= 2'd0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            gl_r    <= group_value_i[HALF_W-1:0];
            gh_r    <= group_value_i[GROUP_W-1:HALF_W];
            pos_r   <= word_position_i;
            step_r  <= 2'd0;
            state_r <= F_MUL;
          end
        end
        F_MUL: begin
          prod_r <= prod_nxt;
          if (step_r == 2'd1) acc_r <= prod_r[GROUP_W-1:HALF_W];
          if (step_r == 2'd2) begin
            acc_r   <= acc_r + prod_r[HALF_W-1:0];
            state_r <= F_PUSH;
          end
          step_r <= step_r + 2'd1;
        end
        default: begin
          if (!full_i) state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/khi_fifo.sv
// Short request queue decoupling the hash front from the table back.
// Depends on khi_pkg for the job type and depth.
module khi_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  khi_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output khi_pkg::job_t head_o,
  output logic          empty_o
);
  import khi_pkg::*;

  job_t              slots [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FPTR_W:0]   count_r;

  assign full_o  = (count_r == (FPTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (count_r == '0);
  assign head_o  = slots[rd_ptr_r];

  function automatic logic [FPTR_W-1:0] ptr_inc(input logic [FPTR_W-1:0] p);
    ptr_inc = (p == FPTR_W'(FIFO_DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push_i) slots[wr_ptr_r] <= push_data_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop_i)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push_i && !pop_i)      count_r <= count_r + 1'b1;
      else if (pop_i && !push_i) count_r <= count_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && full_o)) else $error("request pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop_i && empty_o)) else $error("request popped from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i && !pop_i && rst_n) |=> !empty_o) else $error("queue lost a request");

endmodule

>>> hdl/khi_back.sv
// Back part: owns the hash table (swept to zero after reset), probes the bucket,
// writes the entry or counts a collision, and reports the result. Depends on khi_pkg; drains khi_fifo.
module khi_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     empty_i,
  input  khi_pkg::job_t            head_i,
  output logic                     pop_o,
  output logic                     clearing_o,
  output logic                     out_valid_o,
  output logic                     out_stored_o,
  output logic [2:0]               out_slot_offset_o,
  output logic                     out_bucket_full_o,
  output logic [31:0]              out_entry_value_o,
  output logic [27:0]              out_collision_total_o
);
  import khi_pkg::*;

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_PROBE} bstate_t;

  bstate_t             state_r;
  logic [ADDR_W-1:0]   clr_addr_r;
  logic [INDEX_BITS-1:0] home_r;
  logic [ENTRY_W-1:0]  entry_r;
  logic [SLOT_W-1:0]   k_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                out_valid_r, out_stored_r, out_full_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [ENTRY_W-1:0]  out_entry_r;

  logic [ENTRY_W-1:0]  table_mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]  rd_q;
  logic [ADDR_W-1:0]   probe_addr, raddr, waddr;
  logic                we, slot_empty, last_slot;
  logic [ENTRY_W-1:0]  wdata;

  assign probe_addr = ADDR_W'(home_r) + ADDR_W'(k_r);
  assign slot_empty = (rd_q == '0);
  assign last_slot  = (k_r == SLOT_W'(BUCKET_SLOTS-1));
  assign pop_o      = (state_r == B_IDLE) && !empty_i;
  assign clearing_o = (state_r == B_CLEAR);

  always_comb begin
    raddr = (state_r == B_IDLE) ? ADDR_W'(head_i.home) : probe_addr + 1'b1;
    we    = 1'b0;
    waddr = clr_addr_r;
    wdata = '0;
    unique case (state_r)
      B_CLEAR: we = 1'b1;
      B_PROBE: begin
        we    = slot_empty;
        waddr = probe_addr;
        wdata = entry_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) table_mem[waddr] <= wdata;
    rd_q <= table_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_addr_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        B_CLEAR: begin
          out_valid_r <= 1'b0;
          clr_addr_r  <= clr_addr_r + 1'b1;
          if (clr_addr_r == ADDR_W'(TABLE_DEPTH-1)) state_r <= B_IDLE;
        end
        B_IDLE: begin
          out_valid_r <= 1'b0;
          if (!empty_i) begin
            home_r  <= head_i.home;
            entry_r <= head_i.entry;
            k_r     <= '0;
            state_r <= B_PROBE;
          end
        end
        default: begin
          if (slot_empty) begin
            out_valid_r  <= 1'b1;
            out_stored_r <= 1'b1;
            out_full_r   <= 1'b0;
            out_slot_r   <= k_r;
            out_entry_r  <= entry_r;
            state_r      <= B_IDLE;
          end else if (last_slot) begin
            out_valid_r  <= 1'b1;
            out_stored_r <= 1'b0;
            out_full_r   <= 1'b1;
            out_slot_r   <= '0;
            out_entry_r  <= '0;
            if (cnt_r != COUNT_MAX) cnt_r <= cnt_r + 1'b1;
            state_r      <= B_IDLE;
          end else begin
            out_valid_r <= 1'b0;
            k_r         <= k_r + 1'b1;
          end
        end
      endcase
    end
  end

  assign out_valid_o           = out_valid_r;
  assign out_stored_o          = out_stored_r;
  assign out_slot_offset_o     = out_slot_r;
  assign out_bucket_full_o     = out_full_r;
  assign out_entry_value_o     = out_entry_r;
  assign out_collision_total_o = cnt_r;

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_stored_r != out_full_r)) else $error("result not exclusive");
  a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CLEAR) |-> !out_valid_r && !pop_o) else $error("activity during clear");
  a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r >= $past(cnt_r))) else $error("collision count fell");
  a_full_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_r) |-> (cnt_r != '0)) else $error("full bucket not counted");

endmodule

>>> hdl/kmer_hash_index_insert.sv
// Top level of the k-mer hash index insert block.
// Depends on khi_pkg, khi_front, khi_fifo and khi_back.
// From accepted request to result strobe: the hash (three partial products
//   on one 32x32 multiplier, then the final add), a queue hop, and one table
//   read per probed slot.
// The front takes a new request only once the last is hashed and queued (it
//   holds while the queue is full); the back walks one queued request at a time.
// Reset: rst_n clears control state, then all 1048584 table entries are
//   zeroed, one entry a cycle, with busy high; the receiver cannot stall.
module kmer_hash_index_insert (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_group_value,
  input  logic [26:0] in_word_position,
  output logic        out_valid,
  output logic        out_stored,
  output logic [2:0]  out_slot_offset,
  output logic        out_bucket_full,
  output logic [31:0] out_entry_value,
  output logic [27:0] out_collision_total
);
  import khi_pkg::*;

  job_t push_job, head_job;
  logic push, pop, full, empty, clearing;

  // Hash front: hold the request while the multiplier works, then queue it.
  khi_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start_i         (start),
    .busy_o          (busy),
    .group_value_i   (in_group_value),
    .word_position_i (in_word_position),
    .clearing_i      (clearing),
    .full_i          (full),
    .push_o          (push),
    .job_o           (push_job)
  );

  // Decouple hashing from probing so the next request can be hashed
  // while the back is still walking a bucket.
  khi_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head_job),
    .empty_o     (empty)
  );

  // Table back: probe slots in order, write the first empty one or count
  // a collision, and strobe the result for one cycle.
  khi_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .empty_i               (empty),
    .head_i                (head_job),
    .pop_o                 (pop),
    .clearing_o            (clearing),
    .out_valid_o           (out_valid),
    .out_stored_o          (out_stored),
    .out_slot_offset_o     (out_slot_offset),
    .out_bucket_full_o     (out_bucket_full),
    .out_entry_value_o     (out_entry_value),
    .out_collision_total_o (out_collision_total)
  );

endmodule

>>> tb/tb_top.sv
// Self-checking bench for kmer_hash_index_insert: hashes groups, probes buckets, counts collisions.
// Depends on khi_pkg and the block's RTL; holds a small insert scoreboard and the top module.
// Stimulus targets chosen buckets through the inverse of the hash multiplier.

typedef struct packed {
  logic                        stored;
  logic [khi_pkg::SLOT_W-1:0]  slot_offset;
  logic                        bucket_full;
  logic [khi_pkg::ENTRY_W-1:0] entry_value;
  logic [khi_pkg::CNT_W-1:0]   collision_total;
} insert_outcome_t;

class bucket_insert_board;
  // Sparse copy of the table: a slot never written reads as empty.
  bit [khi_pkg::ENTRY_W-1:0] slot_mem [int unsigned];
  bit [khi_pkg::CNT_W-1:0]   collisions;
  insert_outcome_t           expected_outcomes [$];
  int                        errors;
  int                        insert_count;
  int                        stored_count;
  int                        full_count;
  int                        zero_count;
  int                        deepest;

  function bit [khi_pkg::HALF_W-1:0] group_hash(bit [khi_pkg::GROUP_W-1:0] g);
    bit [khi_pkg::GROUP_W-1:0] prod;
    prod = g * khi_pkg::HASH_MULT;
    return prod[khi_pkg::GROUP_W-1:khi_pkg::HALF_W];
  endfunction

  function bit [khi_pkg::ENTRY_W-1:0] read_slot(int unsigned idx);
    return slot_mem.exists(idx) ? slot_mem[idx] : '0;
  endfunction

  function int pending();
    return expected_outcomes.size();
  endfunction

  // Work out the outcome of one accepted request and update the table copy.
  function void note_insert(bit [khi_pkg::GROUP_W-1:0] g, bit [khi_pkg::POS_W-1:0] pos);
    bit [khi_pkg::HALF_W-1:0] h;
    int unsigned              home;
    insert_outcome_t          o;
    int                       k;
    bit                       found;
    h     = group_hash(g);
    home  = h[khi_pkg::INDEX_BITS-1:0];
    o     = '0;
    found = 1'b0;
    k     = 0;
    for (int i = 0; i < khi_pkg::BUCKET_SLOTS; i++) begin
      if (!found && read_slot(home + i) == '0) begin
        found = 1'b1;
        k     = i;
      end
    end
    insert_count++;
    if (found) begin
      o.stored      = 1'b1;
      o.slot_offset = k[khi_pkg::SLOT_W-1:0];
      o.entry_value = {h[khi_pkg::HALF_W-1:khi_pkg::HALF_W-khi_pkg::CHECK_W], pos};
      slot_mem[home + k] = o.entry_value;
      stored_count++;
      if (o.entry_value == '0) zero_count++;
      if (k > deepest) deepest = k;
    end else begin
      if (collisions < khi_pkg::COUNT_MAX) collisions++;
      o.bucket_full = 1'b1;
      full_count++;
    end
    o.collision_total = collisions;
    expected_outcomes.push_back(o);
  endfunction

  task report(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task check_outcome(insert_outcome_t got);
    insert_outcome_t want;
    if (expected_outcomes.size() == 0) begin
      report($sformatf("result strobe with no request outstanding (entry %0h)",
                       got.entry_value));
    end else begin
      want = expected_outcomes.pop_front();
      if (got.stored !== want.stored)
        report($sformatf("stored %0b, want %0b", got.stored, want.stored));
      if (got.slot_offset !== want.slot_offset)
        report($sformatf("slot_offset %0d, want %0d", got.slot_offset, want.slot_offset));
      if (got.bucket_full !== want.bucket_full)
        report($sformatf("bucket_full %0b, want %0b", got.bucket_full, want.bucket_full));
      if (got.entry_value !== want.entry_value)
        report($sformatf("entry_value %0h, want %0h", got.entry_value, want.entry_value));
      if (got.collision_total !== want.collision_total)
        report($sformatf("collision_total %0d, want %0d",
                         got.collision_total, want.collision_total));
    end
  endtask
endclass

module tb_top;
  import khi_pkg::*;

  localparam int unsigned HOME_MASK      = (1 << INDEX_BITS) - 1;
  localparam int          RANDOM_ITEMS   = 1000;
  localparam int          HOT_HOMES      = 24;
  localparam int          DRAIN_CYCLES   = 16;
  // Idle limit covers the table sweep after reset several times over.
  localparam int unsigned WATCHDOG_LIMIT = 3 * TABLE_DEPTH;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [GROUP_W-1:0]  in_group_value;
  logic [POS_W-1:0]    in_word_position;
  logic                out_valid;
  logic                out_stored;
  logic [SLOT_W-1:0]   out_slot_offset;
  logic                out_bucket_full;
  logic [ENTRY_W-1:0]  out_entry_value;
  logic [CNT_W-1:0]    out_collision_total;

  bucket_insert_board  board = new();
  bit [GROUP_W-1:0]    mult_inv;
  int unsigned         idle_cycles;
  int                  sent;
  bit                  sender_quiet;
  int unsigned         hot_home [HOT_HOMES];

  kmer_hash_index_insert i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_group_value      (in_group_value),
    .in_word_position    (in_word_position),
    .out_valid           (out_valid),
    .out_stored          (out_stored),
    .out_slot_offset     (out_slot_offset),
    .out_bucket_full     (out_bucket_full),
    .out_entry_value     (out_entry_value),
    .out_collision_total (out_collision_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both channels at the rising edge; inputs only move on the falling edge,
  // so every value read here is settled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        board.check_outcome({out_stored, out_slot_offset, out_bucket_full,
                             out_entry_value, out_collision_total});
      if (start && !busy)
        board.note_insert(in_group_value, in_word_position);
      // Restart the idle count on any handshake in either direction.
      if (out_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Give up when nothing moves for far longer than the slowest correct run allows.
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Inverse of the multiplier mod 2^64 by Newton iteration; an odd start is
  // good to three bits and each pass doubles that.
  function automatic bit [GROUP_W-1:0] multiplier_inverse();
    bit [GROUP_W-1:0] x;
    x = HASH_MULT;
    repeat (6) x = x * (64'd2 - HASH_MULT * x);
    return x;
  endfunction

  // Build a group whose hash has the given home slot and checksum bits; the
  // other hash bits and the low half of the product are random.
  function automatic bit [GROUP_W-1:0] group_for(int unsigned home, bit [CHECK_W-1:0] check);
    bit [HALF_W-1:0]  h;
    bit [GROUP_W-1:0] prod;
    h = $urandom;
    h[INDEX_BITS-1:0] = home[INDEX_BITS-1:0];
    h[HALF_W-1:HALF_W-CHECK_W] = check;
    prod = {h, 32'($urandom)};
    return prod * mult_inv;
  endfunction

  function automatic bit [POS_W-1:0] random_position();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '1;
    if (r < 8) return '0;
    return POS_W'($urandom);
  endfunction

  // Hold start low to pause the sender.
  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Offer one request and hold it until the block takes it.
  task automatic send_insert(bit [GROUP_W-1:0] g, bit [POS_W-1:0] pos);
    if (!sender_quiet && $urandom_range(99) < 15) pause_sender($urandom_range(1, 10));
    @(negedge clk);
    start            <= 1'b1;
    in_group_value   <= g;
    in_word_position <= pos;
    do @(posedge clk); while (busy !== 1'b0);
    sent++;
  endtask

  // Drop start and wait until every outstanding request has its result.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned home;
    int          len;
    int          base;
    bit          mid_drain_done;

    rst_n            = 1'b0;
    start            = 1'b0;
    in_group_value   = '0;
    in_word_position = '0;
    idle_cycles      = 0;
    sent             = 0;
    sender_quiet     = 1'b0;
    mid_drain_done   = 1'b0;
    mult_inv         = multiplier_inverse();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A zero group hashes to zero: checksum and position both
    // zero give a zero entry, which the next insert to home 0 must overwrite.
    send_insert('0, '0);
    send_insert('0, '1);
    send_insert(group_for(0, '1), '0);
    send_insert('1, '1);
    // Fill the last home slot's bucket, which runs into the spare slots at the
    // top of the table, then overflow it.
    repeat (BUCKET_SLOTS + 1)
      send_insert(group_for(HOME_MASK, CHECK_W'($urandom)), random_position());
    // The neighbouring bucket has one free slot left, then it is full too.
    repeat (2) send_insert(group_for(HOME_MASK - 1, '1), POS_W'(1));
    send_insert(group_for(5, CHECK_W'($urandom)), random_position());

    // Hold the sender off until the block is empty once.
    drain_results();

    // Hot buckets: some at the table ends, some packed close so their probes overlap.
    for (int i = 0; i < HOT_HOMES; i++) begin
      if (i == 0) hot_home[i] = 0;
      else if (i == 1) hot_home[i] = HOME_MASK;
      else if (i == 2) hot_home[i] = HOME_MASK - 4;
      else if (i % 2 == 1) hot_home[i] = (hot_home[i-1] + $urandom_range(1, 7)) & HOME_MASK;
      else hot_home[i] = $urandom & HOME_MASK;
    end

    base = sent;
    while (sent - base < RANDOM_ITEMS) begin
      // One long stretch with the sender never idling.
      sender_quiet = (sent - base >= 300) && (sent - base < 550);
      if ($urandom_range(99) < 70) begin
        // Burst into one bucket so it may fill and overflow.
        if ($urandom_range(99) < 20)
          hot_home[$urandom_range(HOT_HOMES - 1)] = $urandom & HOME_MASK;
        home = hot_home[$urandom_range(HOT_HOMES - 1)];
        len  = $urandom_range(1, 12);
        repeat (len) begin
          if ($urandom_range(99) < 3) send_insert(group_for(home, '0), '0);
          else send_insert(group_for(home, CHECK_W'($urandom)), random_position());
        end
      end else begin
        send_insert({32'($urandom), 32'($urandom)}, random_position());
      end
      if (!mid_drain_done && sent - base >= 700) begin
        drain_results();
        mid_drain_done = 1'b1;
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d inserts: %0d stored (%0d zero entries), %0d bucket full",
             board.insert_count, board.stored_count, board.zero_count, board.full_count);
    $display("deepest probe offset %0d, collision count %0d, %0d field errors",
             board.deepest, board.collisions, board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/khi_pkg.sv
hdl/khi_front.sv
hdl/khi_fifo.sv
hdl/khi_back.sv
hdl/kmer_hash_index_insert.sv
tb/tb_top.sv
